// ===== hw/rtl/oakit_pkg.sv =====
`default_nettype none

package oakit_pkg;

	// Table geometry and key limits
	localparam int TABLE_SIZE    = 256;
	localparam int MAX_KEY_BYTES = 128;
	localparam int PROBE_STEP    = 13;

	localparam int SLOT_W = $clog2(TABLE_SIZE);
	localparam int CNT_W  = SLOT_W + 1;
	localparam int MPOS_W = $clog2(MAX_KEY_BYTES);
	localparam int BPOS_W = MPOS_W + 1;

	localparam logic [63:0] HASH_SEED = 64'd188546267763;

	// Item kinds
	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_KEY  = 1'b1;

	// Key operations; the unused code behaves as a lookup
	localparam logic [1:0] OP_LOOKUP = 2'd0;
	localparam logic [1:0] OP_SAVE   = 2'd1;
	localparam logic [1:0] OP_INTERN = 2'd2;

	// Result status codes
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_FULL     = 2'd1;
	localparam logic [1:0] STAT_TOO_LONG = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_HASH,
		ST_RDADDR,
		ST_CMP
	} oakit_state_t;

	typedef struct packed {
		logic        kind;
		logic [1:0]  op;
		logic [7:0]  key_byte;
		logic        last_byte;
		logic [6:0]  mult_index;
		logic [63:0] data_word;
	} in_item_t;

	typedef struct packed {
		logic        found;
		logic [63:0] value_out;
		logic [1:0]  status;
	} res_item_t;

endpackage

`default_nettype wire

// ===== hw/rtl/open_address_key_intern_table.sv =====
// Load item: written without leaving idle. Key byte: multiplier read, then multiply and fold.
// Last byte: the result strobe rises after the walk over the home slot and k further probe
// slots (k in 0..255); a zero hash strobes from the fold state and an overlong key right after
// its transfer. Each slot costs a hash memory read (ST_RDADDR) and one compare (ST_CMP).
// Reset clears the slot valid bits and counters and loads the hash seed at once, with no clearing pass;
// multiplier and value memories hold anything until written. Results cannot be stalled.
`default_nettype none

module open_address_key_intern_table (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   start,
	input  wire oakit_pkg::in_item_t item,
	output logic                  busy,
	output logic                  done,
	output oakit_pkg::res_item_t  result
);

	localparam int SW = oakit_pkg::SLOT_W;
	localparam int CW = oakit_pkg::CNT_W;
	localparam int MW = oakit_pkg::MPOS_W;
	localparam int BW = oakit_pkg::BPOS_W;

	oakit_pkg::oakit_state_t state_q, state_d;

	// key and walk registers
	logic [63:0]  hash_q;
	logic [BW-1:0] byte_pos_q;
	logic [7:0]    byte_q;
	logic [1:0]    op_q;
	logic          last_q;
	logic [63:0]   data_q;
	logic [SW-1:0] slot_q;
	logic [SW-1:0] step_q;

	// table bookkeeping
	logic [oakit_pkg::TABLE_SIZE-1:0] valid_q;
	logic [CW-1:0] used_q;
	logic [CW-1:0] next_id_q;

	// memories and their read registers
	logic [63:0] mult_mem  [oakit_pkg::MAX_KEY_BYTES];
	logic [63:0] hash_mem  [oakit_pkg::TABLE_SIZE];
	logic [63:0] value_mem [oakit_pkg::TABLE_SIZE];
	logic [63:0] mult_rd_q;
	logic [63:0] hash_rd_q;
	logic [63:0] value_rd_q;

	logic                 done_q;
	oakit_pkg::res_item_t result_q;

	// control strobes
	logic                 accept;
	logic                 emit;
	oakit_pkg::res_item_t res_d;
	logic                 key_clr;
	logic                 byte_take;
	logic                 hash_upd;
	logic                 mult_we;
	logic                 walk_start;
	logic                 walk_adv;
	logic                 hash_ins;
	logic                 val_we;
	logic [63:0]          val_wd;
	logic                 id_inc;

	logic [71:0] prod_full;
	logic [63:0] hash_nx;
	logic        slot_valid;
	logic        slot_hit;
	logic        is_save;
	logic        is_intern;
	logic        has_room;
	logic [63:0] id_ext;

	assign accept     = start && !busy;
	assign busy       = (state_q != oakit_pkg::ST_IDLE);
	assign done       = done_q;
	assign result     = result_q;

	// shared multiply and fold
	assign prod_full  = mult_rd_q * byte_q;
	assign hash_nx    = hash_q ^ prod_full[63:0];

	assign slot_valid = valid_q[slot_q];
	assign slot_hit   = slot_valid && (hash_rd_q == hash_q);
	assign is_save    = (op_q == oakit_pkg::OP_SAVE);
	assign is_intern  = (op_q == oakit_pkg::OP_INTERN);
	assign has_room   = (used_q < CW'(oakit_pkg::TABLE_SIZE));
	assign id_ext     = {{(64 - CW){1'b0}}, next_id_q};

	// hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= oakit_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequence bytes, the probe walk and the final action
	always_comb begin
		state_d      = state_q;
		emit         = 1'b0;
		res_d        = '0;
		key_clr      = 1'b0;
		byte_take    = 1'b0;
		hash_upd     = 1'b0;
		mult_we      = 1'b0;
		walk_start   = 1'b0;
		walk_adv     = 1'b0;
		hash_ins     = 1'b0;
		val_we       = 1'b0;
		val_wd       = data_q;
		id_inc       = 1'b0;
		case (state_q)
			oakit_pkg::ST_IDLE: begin
				if (accept) begin
					if (item.kind == oakit_pkg::KIND_LOAD) begin
						mult_we = ({1'b0, item.mult_index} < BW'(oakit_pkg::MAX_KEY_BYTES));
					end else if (byte_pos_q < BW'(oakit_pkg::MAX_KEY_BYTES)) begin
						byte_take = 1'b1;
						state_d   = oakit_pkg::ST_HASH;
					end else if (item.last_byte) begin
						// overlong key: the position stays at the limit until the last byte
						emit         = 1'b1;
						res_d.status = oakit_pkg::STAT_TOO_LONG;
						key_clr      = 1'b1;
					end
				end
			end
			oakit_pkg::ST_HASH: begin
				hash_upd = 1'b1;
				if (!last_q) begin
					state_d = oakit_pkg::ST_IDLE;
				end else if (hash_nx == 64'd0) begin
					// a zero hash is turned away: never found, never stored
					emit = 1'b1;
					if (is_save || is_intern) begin
						res_d.status = oakit_pkg::STAT_FULL;
					end
					key_clr = 1'b1;
					state_d = oakit_pkg::ST_IDLE;
				end else begin
					walk_start = 1'b1;
					state_d    = oakit_pkg::ST_RDADDR;
				end
			end
			oakit_pkg::ST_RDADDR: begin
				state_d = oakit_pkg::ST_CMP;
			end
			oakit_pkg::ST_CMP: begin
				if (slot_hit) begin
					emit        = 1'b1;
					res_d.found = 1'b1;
					if (is_save) begin
						val_we = 1'b1;
					end else begin
						res_d.value_out = value_rd_q;
					end
					key_clr = 1'b1;
					state_d = oakit_pkg::ST_IDLE;
				end else if (!slot_valid) begin
					emit = 1'b1;
					if (is_save || is_intern) begin
						if (has_room) begin
							hash_ins = 1'b1;
							val_we   = 1'b1;
							if (is_intern) begin
								val_wd          = id_ext;
								res_d.value_out = id_ext;
								id_inc          = 1'b1;
							end
						end else begin
							res_d.status = oakit_pkg::STAT_FULL;
						end
					end
					key_clr = 1'b1;
					state_d = oakit_pkg::ST_IDLE;
				end else if (step_q == SW'(oakit_pkg::TABLE_SIZE - 1)) begin
					// whole table walked with neither the key nor a free slot
					emit = 1'b1;
					if (is_save || is_intern) begin
						res_d.status = oakit_pkg::STAT_FULL;
					end
					key_clr = 1'b1;
					state_d = oakit_pkg::ST_IDLE;
				end else begin
					walk_adv = 1'b1;
					state_d  = oakit_pkg::ST_RDADDR;
				end
			end
			default: begin
				state_d = oakit_pkg::ST_IDLE;
			end
		endcase
	end

	// hold the key accumulator, position and table counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q     <= oakit_pkg::HASH_SEED;
			byte_pos_q <= '0;
			valid_q    <= '0;
			used_q     <= '0;
			next_id_q  <= '0;
			done_q     <= 1'b0;
		end else begin
			done_q <= emit;
			if (key_clr) begin
				hash_q     <= oakit_pkg::HASH_SEED;
				byte_pos_q <= '0;
			end else if (hash_upd) begin
				hash_q     <= hash_nx;
				byte_pos_q <= byte_pos_q + BW'(1);
			end
			if (hash_ins) begin
				valid_q[slot_q] <= 1'b1;
				used_q          <= used_q + CW'(1);
			end
			if (id_inc) begin
				next_id_q <= next_id_q + CW'(1);
			end
		end
	end

	// capture the byte item, advance the probe slot and hold the result
	always_ff @(posedge clk) begin
		if (byte_take) begin
			byte_q <= item.key_byte;
			op_q   <= item.op;
			last_q <= item.last_byte;
			data_q <= item.data_word;
		end
		if (walk_start) begin
			slot_q <= hash_nx[SW-1:0];
			step_q <= '0;
		end else if (walk_adv) begin
			slot_q <= slot_q + SW'(oakit_pkg::PROBE_STEP);
			step_q <= step_q + SW'(1);
		end
		if (emit) begin
			result_q <= res_d;
		end
	end

	// multiplier memory: load writes, position read
	always_ff @(posedge clk) begin
		if (mult_we) begin
			mult_mem[item.mult_index[MW-1:0]] <= item.data_word;
		end
		mult_rd_q <= mult_mem[byte_pos_q[MW-1:0]];
	end

	// stored hash memory
	always_ff @(posedge clk) begin
		if (hash_ins) begin
			hash_mem[slot_q] <= hash_q;
		end
		hash_rd_q <= hash_mem[slot_q];
	end

	// stored value memory
	always_ff @(posedge clk) begin
		if (val_we) begin
			value_mem[slot_q] <= val_wd;
		end
		value_rd_q <= value_mem[slot_q];
	end

`ifndef NO_ASSERTIONS
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CW'(oakit_pkg::TABLE_SIZE))
		else $error("used count beyond table size");

	a_valid_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(used_q))
		else $error("valid bits disagree with used count");

	a_id_bound: assert property (@(posedge clk) disable iff (!arst_n)
		next_id_q <= used_q)
		else $error("intern id ahead of stored entries");

	a_walk_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == oakit_pkg::ST_RDADDR || state_q == oakit_pkg::ST_CMP) |-> hash_q != 64'd0)
		else $error("probe walk with zero hash");

	a_refused_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && result_q.status != oakit_pkg::STAT_OK)
		|-> (!result_q.found && result_q.value_out == 64'd0))
		else $error("refused result carries data");
`endif

endmodule

`default_nettype wire
